### hw/rtl/svg_pkg.sv
`default_nettype none
package svg_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_RINGS  = 2'd1,
    CFG_SLICES = 2'd2
  } cfg_idx_e;

  localparam int unsigned QueueDepth = 4;
  localparam logic [8:0]  MinRings   = 9'd2;
  localparam logic [8:0]  MinSlices  = 9'd3;

  // Q30 constants
  localparam logic [30:0] OneQ30   = 31'h4000_0000;
  localparam logic [32:0] TwoPiQ30 = 33'd6746518852;

  // Reciprocals for exact floor division of values below 2^31
  localparam int unsigned RecK42 = 37;
  localparam logic [31:0] RecM42 = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam int unsigned RecK56 = 37;
  localparam logic [31:0] RecM56 = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
  localparam int unsigned RecK20 = 36;
  localparam logic [31:0] RecM20 = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam int unsigned RecK30 = 36;
  localparam logic [31:0] RecM30 = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam int unsigned RecK6  = 34;
  localparam logic [31:0] RecM6  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
  localparam int unsigned RecK12 = 35;
  localparam logic [31:0] RecM12 = 32'(((64'd1 << 35) + 64'd11) / 64'd12);

  // Classified vertex request
  typedef struct packed {
    logic [8:0] lat;
    logic [8:0] lon;
    logic [8:0] rings;
    logic [8:0] slices;
    logic       err;
  } item_t;

  // Sine and cosine as sign and Q30 magnitude
  typedef struct packed {
    logic        s_neg;
    logic [30:0] s_mag;
    logic        c_neg;
    logic [30:0] c_mag;
  } sc_t;

  // Q60 product to Q30, round half up
  function automatic logic [30:0] rnd30(input logic [61:0] p);
    logic [61:0] sum;
    sum = p + (62'd1 << 29);
    return sum[60:30];
  endfunction

  // Signed Q30 to Q1.15, round half away from zero, saturate
  function automatic logic [15:0] to_q15(input logic neg, input logic [30:0] mag);
    logic [31:0] sum;
    logic [16:0] r;
    sum = {1'b0, mag} + 32'd16384;
    r   = sum[31:15];
    if (neg) begin
      return 16'(~r + 17'd1);
    end else if (r > 17'd32767) begin
      return 16'h7fff;
    end else begin
      return r[15:0];
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/svg_front.sv
`default_nettype none
module svg_front #(
  parameter int MAX_RINGS  = 256,
  parameter int MAX_SLICES = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [8:0]    lat_index_i,
  input  wire logic [8:0]    lon_index_i,
  input  wire logic [8:0]    ring_count_i,
  input  wire logic [8:0]    slice_count_i,
  input  wire logic          full_i,
  output logic               push_o,
  output svg_pkg::item_t     item_o
);

  localparam logic [8:0] RingCap  = (MAX_RINGS > 511) ? 9'd511 : 9'(MAX_RINGS);
  localparam logic [8:0] SliceCap = (MAX_SLICES > 511) ? 9'd511 : 9'(MAX_SLICES);

  logic           valid_q;
  logic           valid_d;
  svg_pkg::item_t item_q;
  svg_pkg::item_t item_d;

  // Clamp counts and flag out-of-range indexes
  always_comb begin
    item_d.lat = lat_index_i;
    item_d.lon = lon_index_i;
    if (ring_count_i < svg_pkg::MinRings) begin
      item_d.rings = svg_pkg::MinRings;
    end else if (ring_count_i > RingCap) begin
      item_d.rings = RingCap;
    end else begin
      item_d.rings = ring_count_i;
    end
    if (slice_count_i < svg_pkg::MinSlices) begin
      item_d.slices = svg_pkg::MinSlices;
    end else if (slice_count_i > SliceCap) begin
      item_d.slices = SliceCap;
    end else begin
      item_d.slices = slice_count_i;
    end
    item_d.err = (lat_index_i > item_d.rings) || (lon_index_i > item_d.slices);
  end

  // Holding stage in front of the queue
  assign in_stall_o = valid_q && full_i;
  assign push_o     = valid_q && !full_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/svg_queue.sv
`default_nettype none
module svg_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire svg_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output svg_pkg::item_t      item_o
);

  svg_pkg::item_t mem_q [svg_pkg::QueueDepth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 3'(svg_pkg::QueueDepth));
  assign empty_o = (cnt_q == 3'd0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 2'd1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 2'd1 : rd_ptr_q;
    cnt_d    = cnt_q + 3'(push_i) - 3'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/svg_div.sv
`default_nettype none
// Rounded quotient (idx << SHIFT + d/2) / d, one restoring step per stage
module svg_div #(
  parameter int unsigned SHIFT = 16,
  parameter int unsigned QW    = 17
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [8:0]    idx_i,
  input  wire logic [8:0]    div_i,
  output logic [QW-1:0]      quo_o
);

  localparam int unsigned NW = QW + 9;

  logic [NW-1:0] num;
  logic [8:0]    rem_q [QW];
  logic [QW-1:0] nq_q  [QW+1];
  logic [8:0]    d_q   [QW];

  assign num = (NW'(idx_i) << SHIFT) + NW'(div_i >> 1);

  // Load stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num[NW-1:QW];
      nq_q[0]  <= num[QW-1:0];
      d_q[0]   <= div_i;
    end
  end

  // One quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [9:0] trial;
    logic       fit;
    assign trial = {rem_q[i], nq_q[i][QW-1]};
    assign fit   = trial >= {1'b0, d_q[i]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[i+1] <= {nq_q[i][QW-2:0], fit};
      end
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i+1] <= fit ? 9'(trial - {1'b0, d_q[i]}) : trial[8:0];
          d_q[i+1]   <= d_q[i];
        end
      end
    end
  end

  assign quo_o = nq_q[QW];

endmodule
`default_nettype wire

### hw/rtl/svg_sincos.sv
`default_nettype none
// Sine and cosine of an angle in turns: octant fold, then Taylor series in Q30.
// Twelve register stages, at most one multiply per stage and path.
module svg_sincos #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [ANGLE_BITS-1:0] ang_i,
  output svg_pkg::sc_t               sc_o
);

  localparam int unsigned GW = ANGLE_BITS - 2;
  localparam int unsigned PW = ANGLE_BITS + 31;
  localparam logic [GW-1:0] Eighth  = GW'(1) << (GW - 1);
  localparam logic [GW:0]   Quarter = (GW + 1)'(1) << GW;
  localparam logic [PW-1:0] XRound  = PW'(1) << (ANGLE_BITS - 1);

  logic [GW-1:0] frac;
  logic          mir_in;
  logic [GW-1:0] g_in;
  logic [PW-1:0] xsum;

  logic [1:0]    quad_q [11];
  logic          mir_q  [11];
  logic [GW-1:0] g_q;
  logic [PW-1:0] prod_q;
  logic [29:0]   x_q    [8];
  logic [59:0]   xx_q;
  logic [30:0]   x2_q   [6];
  logic [62:0]   ms5_q, mc5_q, ms7_q, mc7_q, ms9_q, mc9_q;
  logic [61:0]   ps6_q, pc6_q, ps8_q, pc8_q, ps10_q, pc10_q;
  svg_pkg::sc_t  sc_q, sc_d;

  logic [30:0]   ts6, tc6, ts8, tc8, ts10, tc10;
  logic [30:0]   sn, cs, s1, c1, cr;

  // Fold to the first octant
  assign frac   = ang_i[GW-1:0];
  assign mir_in = frac > Eighth;
  assign g_in   = mir_in ? GW'(Quarter - {1'b0, frac}) : frac;
  assign xsum   = prod_q + XRound;

  // Series terms
  assign ts6  = svg_pkg::OneQ30 - 31'(ms5_q >> svg_pkg::RecK42);
  assign tc6  = svg_pkg::OneQ30 - 31'(mc5_q >> svg_pkg::RecK56);
  assign ts8  = svg_pkg::OneQ30 - 31'(ms7_q >> svg_pkg::RecK20);
  assign tc8  = svg_pkg::OneQ30 - 31'(mc7_q >> svg_pkg::RecK30);
  assign ts10 = svg_pkg::OneQ30 - 31'(ms9_q >> svg_pkg::RecK6);
  assign tc10 = svg_pkg::OneQ30 - 31'(mc9_q >> svg_pkg::RecK12);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= ang_i[ANGLE_BITS-1:ANGLE_BITS-2];
      mir_q[0]  <= mir_in;
      for (int k = 1; k < 11; k++) begin
        quad_q[k] <= quad_q[k-1];
        mir_q[k]  <= mir_q[k-1];
      end
      g_q    <= g_in;
      // radians in Q30
      prod_q <= PW'(g_q) * PW'(svg_pkg::TwoPiQ30);
      x_q[0] <= xsum[ANGLE_BITS+29:ANGLE_BITS];
      for (int k = 1; k < 8; k++) begin
        x_q[k] <= x_q[k-1];
      end
      xx_q    <= x_q[0] * x_q[0];
      x2_q[0] <= svg_pkg::rnd30({2'b00, xx_q});
      for (int k = 1; k < 6; k++) begin
        x2_q[k] <= x2_q[k-1];
      end
      // nested Horner steps, sine on s, cosine on c
      ms5_q  <= 63'(x2_q[0] + 31'd21) * 63'(svg_pkg::RecM42);
      mc5_q  <= 63'(x2_q[0] + 31'd28) * 63'(svg_pkg::RecM56);
      ps6_q  <= 62'(x2_q[1]) * 62'(ts6);
      pc6_q  <= 62'(x2_q[1]) * 62'(tc6);
      ms7_q  <= 63'(svg_pkg::rnd30(ps6_q) + 31'd10) * 63'(svg_pkg::RecM20);
      mc7_q  <= 63'(svg_pkg::rnd30(pc6_q) + 31'd15) * 63'(svg_pkg::RecM30);
      ps8_q  <= 62'(x2_q[3]) * 62'(ts8);
      pc8_q  <= 62'(x2_q[3]) * 62'(tc8);
      ms9_q  <= 63'(svg_pkg::rnd30(ps8_q) + 31'd3) * 63'(svg_pkg::RecM6);
      mc9_q  <= 63'(svg_pkg::rnd30(pc8_q) + 31'd6) * 63'(svg_pkg::RecM12);
      ps10_q <= 62'(x_q[7]) * 62'(ts10);
      pc10_q <= 62'(x2_q[5]) * 62'(tc10);
      sc_q   <= sc_d;
    end
  end

  // Final terms, unfold octant and quadrant
  always_comb begin
    sn = svg_pkg::rnd30(ps10_q);
    cr = svg_pkg::rnd30(pc10_q);
    cs = svg_pkg::OneQ30 - 31'((32'(cr) + 32'd1) >> 1);
    s1 = mir_q[10] ? cs : sn;
    c1 = mir_q[10] ? sn : cs;
    case (quad_q[10])
      2'd0: begin
        sc_d = '{s_neg: 1'b0, s_mag: s1, c_neg: 1'b0, c_mag: c1};
      end
      2'd1: begin
        sc_d = '{s_neg: 1'b0, s_mag: c1, c_neg: 1'b1, c_mag: s1};
      end
      2'd2: begin
        sc_d = '{s_neg: 1'b1, s_mag: s1, c_neg: 1'b1, c_mag: c1};
      end
      default: begin
        sc_d = '{s_neg: 1'b1, s_mag: c1, c_neg: 1'b0, c_mag: s1};
      end
    endcase
  end

  assign sc_o = sc_q;

endmodule
`default_nettype wire

### hw/rtl/svg_back.sv
`default_nettype none
// Execution pipeline: dividers, two sine-cosine units, normal and position.
// The whole pipeline advances unless the output register is held by a stall.
module svg_back #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire svg_pkg::item_t item_i,
  output logic                pop_o,
  input  wire logic [15:0]    radius_i,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output logic signed [16:0]  pos_x_o,
  output logic signed [16:0]  pos_y_o,
  output logic signed [16:0]  pos_z_o,
  output logic [16:0]         tex_u_o,
  output logic [16:0]         tex_v_o,
  output logic signed [15:0]  norm_x_o,
  output logic signed [15:0]  norm_y_o,
  output logic signed [15:0]  norm_z_o,
  output logic signed [15:0]  tan_x_o,
  output logic signed [15:0]  tan_z_o,
  output logic                index_error_o
);

  localparam int unsigned A    = ANGLE_BITS;
  localparam int unsigned QMax = ((A > 16) ? A : 16) + 1;
  localparam int unsigned LatD = QMax + 1;
  localparam int unsigned Lat  = LatD + 16;
  localparam int unsigned TexD = 15;
  localparam logic [A-1:0] PhBase = A'(1) << (A - 2);

  logic            en;
  logic [Lat-1:0]  vld_q;
  logic [Lat-2:0]  err_q;
  logic [QMax-1:0] quo_th, quo_u, quo_pl, quo_v;
  logic [A-1:0]    ang_th, ang_ph;
  logic [16:0]     tex_u_q [TexD];
  logic [16:0]     tex_v_q [TexD];
  svg_pkg::sc_t    sc_th, sc_ph;

  // normal and position stages
  logic [61:0]  nxp_q, nzp_q;
  logic         nx0_neg_q, nz0_neg_q;
  logic [30:0]  nx_q, nz_q;
  logic         nx1_neg_q, nz1_neg_q;
  logic [46:0]  px_q, py_q, pz_q;
  logic [30:0]  nx2_q, nz2_q;
  logic         nx2_neg_q, nz2_neg_q;
  svg_pkg::sc_t th_q [3];
  svg_pkg::sc_t ph_q [3];

  // Radius times Q30 magnitude to signed Q8.8
  function automatic logic [16:0] to_pos(input logic neg, input logic [46:0] p);
    logic [46:0] sum;
    logic [16:0] r;
    sum = p + (47'd1 << 29);
    r   = sum[46:30];
    return neg ? (~r + 17'd1) : r;
  endfunction

  assign en          = !(vld_q[Lat-1] && out_stall_i);
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], pop_o};
    end
  end

  // Angle, texture quotients
  svg_div #(.SHIFT(A), .QW(QMax)) u_div_th (
    .clk_i(clk_i), .en_i(en), .idx_i(item_i.lon), .div_i(item_i.slices), .quo_o(quo_th)
  );
  svg_div #(.SHIFT(16), .QW(QMax)) u_div_u (
    .clk_i(clk_i), .en_i(en), .idx_i(item_i.lon), .div_i(item_i.slices), .quo_o(quo_u)
  );
  svg_div #(.SHIFT(A - 1), .QW(QMax)) u_div_pl (
    .clk_i(clk_i), .en_i(en), .idx_i(item_i.lat), .div_i(item_i.rings), .quo_o(quo_pl)
  );
  svg_div #(.SHIFT(16), .QW(QMax)) u_div_v (
    .clk_i(clk_i), .en_i(en), .idx_i(item_i.lat), .div_i(item_i.rings), .quo_o(quo_v)
  );

  assign ang_th = quo_th[A-1:0];
  assign ang_ph = PhBase - quo_pl[A-1:0];

  svg_sincos #(.ANGLE_BITS(A)) u_sc_th (
    .clk_i(clk_i), .en_i(en), .ang_i(ang_th), .sc_o(sc_th)
  );
  svg_sincos #(.ANGLE_BITS(A)) u_sc_ph (
    .clk_i(clk_i), .en_i(en), .ang_i(ang_ph), .sc_o(sc_ph)
  );

  // Side data delay lines
  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q      <= {err_q[Lat-3:0], item_i.err};
      tex_u_q[0] <= quo_u[16:0];
      tex_v_q[0] <= 17'd65536 - quo_v[16:0];
      for (int k = 1; k < TexD; k++) begin
        tex_u_q[k] <= tex_u_q[k-1];
        tex_v_q[k] <= tex_v_q[k-1];
      end
    end
  end

  // Normal products, rounding, radius scaling
  always_ff @(posedge clk_i) begin
    if (en) begin
      nxp_q     <= 62'(sc_th.c_mag) * 62'(sc_ph.c_mag);
      nzp_q     <= 62'(sc_th.s_mag) * 62'(sc_ph.c_mag);
      nx0_neg_q <= sc_th.c_neg ^ sc_ph.c_neg;
      nz0_neg_q <= sc_th.s_neg ^ sc_ph.c_neg;
      th_q[0]   <= sc_th;
      ph_q[0]   <= sc_ph;

      nx_q      <= svg_pkg::rnd30(nxp_q);
      nz_q      <= svg_pkg::rnd30(nzp_q);
      nx1_neg_q <= nx0_neg_q;
      nz1_neg_q <= nz0_neg_q;
      th_q[1]   <= th_q[0];
      ph_q[1]   <= ph_q[0];

      px_q      <= 47'(radius_i) * 47'(nx_q);
      py_q      <= 47'(radius_i) * 47'(ph_q[1].s_mag);
      pz_q      <= 47'(radius_i) * 47'(nz_q);
      nx2_q     <= nx_q;
      nz2_q     <= nz_q;
      nx2_neg_q <= nx1_neg_q;
      nz2_neg_q <= nz1_neg_q;
      th_q[2]   <= th_q[1];
      ph_q[2]   <= ph_q[1];
    end
  end

  // Output register, fields cleared on an index error
  always_ff @(posedge clk_i) begin
    if (en) begin
      index_error_o <= err_q[Lat-2];
      if (err_q[Lat-2]) begin
        pos_x_o  <= '0;
        pos_y_o  <= '0;
        pos_z_o  <= '0;
        tex_u_o  <= '0;
        tex_v_o  <= '0;
        norm_x_o <= '0;
        norm_y_o <= '0;
        norm_z_o <= '0;
        tan_x_o  <= '0;
        tan_z_o  <= '0;
      end else begin
        pos_x_o  <= to_pos(nx2_neg_q, px_q);
        pos_y_o  <= to_pos(ph_q[2].s_neg, py_q);
        pos_z_o  <= to_pos(nz2_neg_q, pz_q);
        tex_u_o  <= tex_u_q[TexD-1];
        tex_v_o  <= tex_v_q[TexD-1];
        norm_x_o <= svg_pkg::to_q15(nx2_neg_q, nx2_q);
        norm_y_o <= svg_pkg::to_q15(ph_q[2].s_neg, ph_q[2].s_mag);
        norm_z_o <= svg_pkg::to_q15(nz2_neg_q, nz2_q);
        tan_x_o  <= svg_pkg::to_q15(th_q[2].s_neg, th_q[2].s_mag);
        tan_z_o  <= svg_pkg::to_q15(!th_q[2].c_neg, th_q[2].c_mag);
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sphere_vertex_generator_core.sv
// UV sphere vertex generator.
// Input channel (in_valid_i / in_stall_o) carries one (lat, lon) grid index
// per transaction; output channel (out_valid_o / out_stall_i) returns one
// vertex per input: Q8.8 position, Q1.16 texture coordinates, Q1.15 normal
// and tangent x/z, and an index_error flag (all other fields zero then).
// The configuration channel writes radius, ring count and slice count by
// index (0, 1, 2); writes are taken every cycle, other indexes are dropped.
// Write configuration only while no vertex is in flight.
// The pipeline depth is set by the bit-per-stage dividers (one stage per
// quotient bit) followed by the twelve-stage sine-cosine units and four
// normal/position stages. Throughput: one vertex per cycle while the
// receiver does not stall.
// Reset clears the pipeline and a four-entry queue and loads radius 1.0,
// 16 rings and 16 slices. When the receiver stalls, the execution pipeline
// freezes and the output holds; the queue and front stage keep taking up to
// five more vertices before in_stall_o rises.
`default_nettype none
module sphere_vertex_generator_core #(
  parameter int MAX_RINGS  = 256,
  parameter int MAX_SLICES = 256,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [8:0]         lat_index_i,
  input  wire logic [8:0]         lon_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [16:0]      pos_x_o,
  output logic signed [16:0]      pos_y_o,
  output logic signed [16:0]      pos_z_o,
  output logic [16:0]             tex_u_o,
  output logic [16:0]             tex_v_o,
  output logic signed [15:0]      norm_x_o,
  output logic signed [15:0]      norm_y_o,
  output logic signed [15:0]      norm_z_o,
  output logic signed [15:0]      tan_x_o,
  output logic signed [15:0]      tan_z_o,
  output logic                    index_error_o
);

  logic [15:0]    radius_q;
  logic [8:0]     rings_q;
  logic [8:0]     slices_q;
  logic           q_full, q_empty, push, pop;
  svg_pkg::item_t front_item, queue_item;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd256;
      rings_q  <= 9'd16;
      slices_q <= 9'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (svg_pkg::cfg_idx_e'(cfg_index_i))
        svg_pkg::CFG_RADIUS: radius_q <= cfg_data_i;
        svg_pkg::CFG_RINGS:  rings_q  <= cfg_data_i[8:0];
        svg_pkg::CFG_SLICES: slices_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  svg_front #(.MAX_RINGS(MAX_RINGS), .MAX_SLICES(MAX_SLICES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .lat_index_i   (lat_index_i),
    .lon_index_i   (lon_index_i),
    .ring_count_i  (rings_q),
    .slice_count_i (slices_q),
    .full_i        (q_full),
    .push_o        (push),
    .item_o        (front_item)
  );

  svg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (queue_item)
  );

  svg_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .item_i        (queue_item),
    .pop_o         (pop),
    .radius_i      (radius_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .norm_x_o      (norm_x_o),
    .norm_y_o      (norm_y_o),
    .norm_z_o      (norm_z_o),
    .tan_x_o       (tan_x_o),
    .tan_z_o       (tan_z_o),
    .index_error_o (index_error_o)
  );

endmodule
`default_nettype wire

### hw/rtl/svg_checker.sv
`default_nettype none
module svg_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [1:0]         cfg_index_i,
  input wire logic [15:0]        cfg_data_i,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [8:0]         lat_index_i,
  input wire logic [8:0]         lon_index_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [16:0] pos_x_o,
  input wire logic signed [16:0] pos_y_o,
  input wire logic signed [16:0] pos_z_o,
  input wire logic [16:0]        tex_u_o,
  input wire logic [16:0]        tex_v_o,
  input wire logic signed [15:0] norm_x_o,
  input wire logic signed [15:0] norm_y_o,
  input wire logic signed [15:0] norm_z_o,
  input wire logic signed [15:0] tan_x_o,
  input wire logic signed [15:0] tan_z_o,
  input wire logic               index_error_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pos_x_o) && $stable(norm_y_o) &&
      $stable(tex_u_o) && $stable(index_error_o))
    else $error("output payload changed while stalled");

  // Bad index gives an all-zero vertex
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> pos_x_o == 0 && pos_y_o == 0 &&
      pos_z_o == 0 && tex_u_o == 0 && tex_v_o == 0 && norm_x_o == 0 &&
      norm_y_o == 0 && norm_z_o == 0 && tan_x_o == 0 && tan_z_o == 0)
    else $error("index error with non-zero fields");

  // Texture coordinates stay within one
  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !index_error_o |-> tex_u_o <= 17'd65536 && tex_v_o <= 17'd65536)
    else $error("texture coordinate above one");

endmodule

bind sphere_vertex_generator_core svg_checker u_svg_checker (.*);
`default_nettype wire
